// File: hw/rtl/gpk_pkg.sv
package gpk_pkg;

    // peak count and exp table size
    localparam int MAX_PEAKS = 3;
    localparam int EXP_D     = 256;
    localparam int EXP_TW    = $clog2(EXP_D + 1);

    // 1/sqrt(2*pi) in Q0.32
    localparam logic [30:0] INV_SQRT_2PI = 31'd1713444047;

    // datapath widths
    localparam int C_W    = 30;              // bin_width/sqrt(2pi), Q16.16
    localparam int A_N    = C_W + 16;        // amplitude dividend / quotient bits
    localparam int U_W    = 20;              // normalized distance, below 16.0
    localparam int Z_W    = 2 * U_W - 17;    // squared distance
    localparam int ZD_W   = Z_W + EXP_TW;    // squared distance times table depth
    localparam int E_W    = 17;              // exp value, Q1.16
    localparam int G_W    = A_N + E_W - 16;  // peak height
    localparam int AA_W   = 32;              // |area|
    localparam int GL_W   = 24;              // low split of height for partial products
    localparam int FULL_W = G_W + AA_W;
    localparam int MAG_W  = 49;
    localparam int TERM_W = MAG_W + 1;
    localparam int BG_W   = 49;
    localparam int SA_W   = TERM_W + 1;
    localparam int SUM_W  = SA_W + 1;
    localparam int OUT_W  = 48;

    // stage numbers inside one peak lane (stage 0 follows the input register)
    localparam int ST_ADIV = A_N / 2;        // two quotient bits per stage
    localparam int ST_UDIV = U_W / 2;
    localparam int ST_Z    = ST_UDIV + 1;
    localparam int ST_POS  = ST_UDIV + 2;
    localparam int ST_LU   = ST_UDIV + 3;
    localparam int ST_MUL  = ST_UDIV + 4;
    localparam int ST_E    = ST_UDIV + 5;
    localparam int ST_G    = ST_ADIV + 1;
    localparam int ST_PP   = ST_G + 1;
    localparam int ST_TERM = ST_PP + 1;

    // stage numbers of the top level valid chain
    localparam int IX_SA  = ST_TERM + 2;
    localparam int IX_SUM = IX_SA + 1;
    localparam int IX_OUT = IX_SUM + 1;

    // register map
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_PEAK_COUNT   = 2'd0;
    localparam logic [1:0] REG_SHARED_WIDTH = 2'd1;
    localparam logic [1:0] REG_BIN_WIDTH    = 2'd2;

    // exp(-16/EXP_D) in Q30: Taylor terms, each floored; later terms are zero
    // for any table depth of 64 or more
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned TY_1  = (Q30_ONE * 16) / (EXP_D * 1);
    localparam longint unsigned TY_2  = (TY_1 * 16) / (EXP_D * 2);
    localparam longint unsigned TY_3  = (TY_2 * 16) / (EXP_D * 3);
    localparam longint unsigned TY_4  = (TY_3 * 16) / (EXP_D * 4);
    localparam longint unsigned TY_5  = (TY_4 * 16) / (EXP_D * 5);
    localparam longint unsigned TY_6  = (TY_5 * 16) / (EXP_D * 6);
    localparam longint unsigned TY_7  = (TY_6 * 16) / (EXP_D * 7);
    localparam longint unsigned TY_8  = (TY_7 * 16) / (EXP_D * 8);
    localparam longint unsigned TY_9  = (TY_8 * 16) / (EXP_D * 9);
    localparam longint unsigned TY_10 = (TY_9 * 16) / (EXP_D * 10);
    localparam longint unsigned EXP_STEP = Q30_ONE - TY_1 + TY_2 - TY_3 + TY_4 - TY_5
                                           + TY_6 - TY_7 + TY_8 - TY_9 + TY_10;

    typedef logic [E_W-1:0] t_exp_tab [0:EXP_D];

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] area;
        logic signed [31:0] center;
        logic [30:0]        width;
        logic               used;
        logic [C_W-1:0]     c;
    } t_pk_in;

    typedef struct packed {
        logic signed [TERM_W-1:0] term;
        logic                     over;
        logic                     bad;
    } t_pk_out;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [31:0] div_step(input logic [30:0] rem, input logic b,
                                             input logic [30:0] dvs);
        logic [31:0] t;
        logic [31:0] r;
        logic        q;
        t = {rem, b};
        if (t >= {1'b0, dvs}) begin
            r = t - {1'b0, dvs};
            q = 1'b1;
        end else begin
            r = t;
            q = 1'b0;
        end
        return {q, r[30:0]};
    endfunction

    // exp(-16*k/EXP_D) in Q1.16, repeated rounded products of the Q30 step
    function automatic t_exp_tab exp_tab_build();
        t_exp_tab        tab;
        longint unsigned v;
        v = Q30_ONE;
        for (int k = 0; k <= EXP_D; k++) begin
            tab[k] = E_W'((v + 64'd8192) >> 14);
            v = (v * EXP_STEP + (Q30_ONE >> 1)) >> 30;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = exp_tab_build();

endpackage

// File: hw/rtl/gpk_peak.sv
module gpk_peak (
    input  logic             i_clk,
    input  logic             i_en,
    input  gpk_pkg::t_pk_in  i_pk,
    output gpk_pkg::t_pk_out o_pk
);

    typedef struct packed {
        logic                     neg;
        logic [gpk_pkg::AA_W-1:0] aa;
        logic                     kill;
        logic                     bad;
        logic                     far;
    } t_side;

    // stage 0 inputs
    logic signed [32:0] d;
    logic [32:0]        ad;
    logic               far;
    logic [31:0]        aa;

    t_side r_side [0:gpk_pkg::ST_TERM-1];
    logic [30:0] r_w [0:gpk_pkg::ST_ADIV-1];

    // amplitude divider
    logic [30:0]              r_ar [0:gpk_pkg::ST_ADIV-1];
    logic [gpk_pkg::A_N-1:0]  r_ab [0:gpk_pkg::ST_ADIV-1];
    logic [gpk_pkg::A_N-1:0]  r_aq [0:gpk_pkg::ST_ADIV];

    // distance divider
    logic [30:0]              r_ur [0:gpk_pkg::ST_UDIV-1];
    logic [gpk_pkg::U_W-1:0]  r_ub [0:gpk_pkg::ST_UDIV-1];
    logic [gpk_pkg::U_W-1:0]  r_uq [0:gpk_pkg::ST_UDIV];

    // exp section
    logic [2*gpk_pkg::U_W-1:0]  usq;
    logic [gpk_pkg::Z_W-1:0]    r_z;
    logic [gpk_pkg::ZD_W-1:0]   zd;
    logic [gpk_pkg::ZD_W-21:0]  r_idx;
    logic [15:0]                r_f;
    logic                       idx_over;
    logic [gpk_pkg::EXP_TW-1:0] ix_lo;
    logic [gpk_pkg::EXP_TW-1:0] ix_hi;
    logic [gpk_pkg::E_W-1:0]    r_lo;
    logic [gpk_pkg::E_W-1:0]    r_hi;
    logic [15:0]                r_f2;
    logic                       r_ez;
    logic [gpk_pkg::E_W-1:0]    diff;
    logic [gpk_pkg::E_W+15:0]   r_prod;
    logic [gpk_pkg::E_W-1:0]    r_lo2;
    logic                       r_dn;
    logic                       r_ez2;
    logic [gpk_pkg::E_W-1:0]    r_e [gpk_pkg::ST_E:gpk_pkg::ST_ADIV];
    logic [gpk_pkg::E_W-1:0]    e_n;

    // term section
    logic [gpk_pkg::A_N+gpk_pkg::E_W-1:0]       ge;
    logic [gpk_pkg::G_W-1:0]                    r_g;
    logic [gpk_pkg::GL_W+gpk_pkg::AA_W-1:0]     r_pl;
    logic [gpk_pkg::FULL_W-gpk_pkg::GL_W-1:0]   r_ph;
    logic [gpk_pkg::FULL_W-1:0]                 full;
    logic                                       over;
    logic [gpk_pkg::MAG_W-1:0]                  mag;
    gpk_pkg::t_pk_out                           r_out;

    always_comb begin
        d   = {i_pk.x[31], i_pk.x} - {i_pk.center[31], i_pk.center};
        ad  = d[32] ? (~d + 33'd1) : d;
        far = {2'b0, ad} >= {i_pk.width, 4'b0};
        aa  = i_pk.area[31] ? (~i_pk.area + 32'd1) : i_pk.area;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0].neg  <= i_pk.area[31];
            r_side[0].aa   <= aa;
            r_side[0].kill <= !i_pk.used || (i_pk.width == '0);
            r_side[0].bad  <= i_pk.used && (i_pk.width == '0);
            r_side[0].far  <= far;
            r_w[0]         <= i_pk.width;
            r_ar[0]        <= '0;
            r_ab[0]        <= {i_pk.c, 16'd0};
            r_aq[0]        <= '0;
            r_ur[0]        <= {2'b0, ad[32:4]};
            r_ub[0]        <= {ad[3:0], 16'd0};
            r_uq[0]        <= '0;
            for (int s = 1; s < gpk_pkg::ST_TERM; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int s = 1; s < gpk_pkg::ST_ADIV; s++) begin
                r_w[s] <= r_w[s-1];
            end
        end
    end

    // amplitude = (c << 16) / w, two bits per stage
    for (genvar s = 1; s <= gpk_pkg::ST_ADIV; s++) begin : g_adiv
        logic [31:0] st1;
        logic [31:0] st2;
        assign st1 = gpk_pkg::div_step(r_ar[s-1], r_ab[s-1][gpk_pkg::A_N-1], r_w[s-1]);
        assign st2 = gpk_pkg::div_step(st1[30:0], r_ab[s-1][gpk_pkg::A_N-2], r_w[s-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_aq[s] <= {r_aq[s-1][gpk_pkg::A_N-3:0], st1[31], st2[31]};
            end
        end
        if (s < gpk_pkg::ST_ADIV) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ar[s] <= st2[30:0];
                    r_ab[s] <= {r_ab[s-1][gpk_pkg::A_N-3:0], 2'b00};
                end
            end
        end
    end

    // distance u = (|x-mean| << 16) / w, only the low 20 quotient bits matter
    for (genvar s = 1; s <= gpk_pkg::ST_UDIV; s++) begin : g_udiv
        logic [31:0] st1;
        logic [31:0] st2;
        assign st1 = gpk_pkg::div_step(r_ur[s-1], r_ub[s-1][gpk_pkg::U_W-1], r_w[s-1]);
        assign st2 = gpk_pkg::div_step(st1[30:0], r_ub[s-1][gpk_pkg::U_W-2], r_w[s-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_uq[s] <= {r_uq[s-1][gpk_pkg::U_W-3:0], st1[31], st2[31]};
            end
        end
        if (s < gpk_pkg::ST_UDIV) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ur[s] <= st2[30:0];
                    r_ub[s] <= {r_ub[s-1][gpk_pkg::U_W-3:0], 2'b00};
                end
            end
        end
    end

    always_comb begin
        usq      = r_uq[gpk_pkg::ST_UDIV] * r_uq[gpk_pkg::ST_UDIV];
        zd       = r_z * gpk_pkg::ZD_W'(gpk_pkg::EXP_D);
        idx_over = r_idx >= ($bits(r_idx))'(gpk_pkg::EXP_D);
        ix_lo    = idx_over ? '0 : r_idx[gpk_pkg::EXP_TW-1:0];
        ix_hi    = ix_lo + 1'b1;
        diff     = (r_lo >= r_hi) ? (r_lo - r_hi) : (r_hi - r_lo);
        if (r_ez2) begin
            e_n = '0;
        end else if (r_dn) begin
            e_n = r_lo2 - r_prod[gpk_pkg::E_W+15:16];
        end else begin
            e_n = r_lo2 + r_prod[gpk_pkg::E_W+15:16];
        end
        ge = r_aq[gpk_pkg::ST_ADIV] * r_e[gpk_pkg::ST_ADIV];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // squared distance / 2
            r_z    <= usq[2*gpk_pkg::U_W-1:17];
            // table position
            r_idx  <= zd[gpk_pkg::ZD_W-1:20];
            r_f    <= zd[19:4];
            // table lookup
            r_lo   <= gpk_pkg::EXP_TAB[ix_lo];
            r_hi   <= gpk_pkg::EXP_TAB[ix_hi];
            r_f2   <= r_f;
            r_ez   <= idx_over || r_side[gpk_pkg::ST_LU-1].far;
            // interpolation
            r_prod <= diff * r_f2;
            r_lo2  <= r_lo;
            r_dn   <= r_lo >= r_hi;
            r_ez2  <= r_ez;
            r_e[gpk_pkg::ST_E] <= e_n;
            for (int s = gpk_pkg::ST_E + 1; s <= gpk_pkg::ST_ADIV; s++) begin
                r_e[s] <= r_e[s-1];
            end
            // height and area product, split in two partial products
            r_g  <= ge[gpk_pkg::G_W+15:16];
            r_pl <= r_g[gpk_pkg::GL_W-1:0] * r_side[gpk_pkg::ST_PP-1].aa;
            r_ph <= r_g[gpk_pkg::G_W-1:gpk_pkg::GL_W] * r_side[gpk_pkg::ST_PP-1].aa;
        end
    end

    always_comb begin
        full = {r_ph, {gpk_pkg::GL_W{1'b0}}} + gpk_pkg::FULL_W'(r_pl);
        over = |full[gpk_pkg::FULL_W-1:63];
        mag  = over ? (gpk_pkg::MAG_W'(1) << 48) : gpk_pkg::MAG_W'(full[62:16]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_side[gpk_pkg::ST_TERM-1].kill) begin
                r_out.term <= '0;
                r_out.over <= 1'b0;
            end else begin
                r_out.term <= r_side[gpk_pkg::ST_TERM-1].neg
                              ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                r_out.over <= over;
            end
            r_out.bad <= r_side[gpk_pkg::ST_TERM-1].bad;
        end
    end

    assign o_pk = r_out;

endmodule

// File: hw/rtl/gaussian_peaks_on_linear_background.sv
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_stall    sample_position, bg_level, bg_slope,
//                                          area_k, center_k, width_k (k = 0..2)
// result   out        o_valid / i_stall    model_value, saturated, bad_width
// config   in         APB psel/penable     peak_count @0x0, shared_width @0x4,
//                                          bin_width @0x8
//
// One transaction per cycle is taken while the pipe is not stalled.
// Each peak lane has two radix-4 restoring dividers; the depth is set by the
// amplitude one (23 stages) plus height, product and sum stages.
// i_rst_n is synchronous: it clears the valid chain and restores the registers.
// The whole pipe holds while the output register is full and stalled; nothing
// is dropped or repeated, and bubbles simply flow through.
module gaussian_peaks_on_linear_background (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [31:0]          i_sample_position,
    input  logic signed [31:0]          i_bg_level,
    input  logic signed [31:0]          i_bg_slope,
    input  logic signed [31:0]          i_area_0,
    input  logic signed [31:0]          i_center_0,
    input  logic [30:0]                 i_width_0,
    input  logic signed [31:0]          i_area_1,
    input  logic signed [31:0]          i_center_1,
    input  logic [30:0]                 i_width_1,
    input  logic signed [31:0]          i_area_2,
    input  logic signed [31:0]          i_center_2,
    input  logic [30:0]                 i_width_2,

    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [47:0]          o_model_value,
    output logic                        o_saturated,
    output logic                        o_bad_width,

    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gpk_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // configuration registers
    logic [1:0]  r_peak_count;
    logic        r_shared_width;
    logic [30:0] r_bin_width;
    logic [61:0] cprod;
    logic [gpk_pkg::C_W-1:0] r_c;    // bin_width / sqrt(2*pi), follows bin_width
    logic [1:0]  reg_ix;
    logic        cfg_wr;

    // pipeline control: one valid bit per stage, common advance enable
    logic        en;
    logic        r_vld [0:gpk_pkg::IX_OUT];

    // stage 0: captured transaction
    logic signed [31:0] r_x;
    logic signed [31:0] r_lvl;
    logic signed [31:0] r_slope;
    logic signed [31:0] in_area [0:2];
    logic signed [31:0] in_ctr  [0:2];
    logic [30:0]        in_wid  [0:2];
    logic signed [31:0] r_area [0:gpk_pkg::MAX_PEAKS-1];
    logic signed [31:0] r_ctr  [0:gpk_pkg::MAX_PEAKS-1];
    logic [30:0]        r_wid  [0:gpk_pkg::MAX_PEAKS-1];
    logic               r_used [0:gpk_pkg::MAX_PEAKS-1];

    // background lane: slope*x then level added, delayed to meet the peaks
    logic signed [63:0]               r_bgp;
    logic signed [31:0]               r_lvl_d;   // level, in step with r_bgp
    logic signed [gpk_pkg::BG_W-1:0]  r_bg [2:gpk_pkg::IX_SA-1];

    // peak lanes
    gpk_pkg::t_pk_in  pk_in  [0:gpk_pkg::MAX_PEAKS-1];
    gpk_pkg::t_pk_out pk_out [0:gpk_pkg::MAX_PEAKS-1];

    // summing and clipping
    logic signed [gpk_pkg::SA_W-1:0]  sa;
    logic signed [gpk_pkg::SA_W-1:0]  sb;
    logic                             ov_any;
    logic                             bad_any;
    logic signed [gpk_pkg::SA_W-1:0]  r_sa;
    logic signed [gpk_pkg::SA_W-1:0]  r_sb;
    logic                             r_ov_sa;
    logic                             r_bad_sa;
    logic signed [gpk_pkg::SUM_W-1:0] r_sum;
    logic                             r_ov_sum;
    logic                             r_bad_sum;
    logic                             clip;
    logic signed [gpk_pkg::OUT_W-1:0] r_out_value;
    logic                             r_out_sat;
    logic                             r_out_bad;

    // ---------------------------------------------------------------
    // Configuration port. Writes land on the access cycle; reads are a
    // plain mux on the word address.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign reg_ix = paddr[3:2];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_count   <= 2'd1;
            r_shared_width <= 1'b0;
            r_bin_width    <= 31'd65536;
        end else if (cfg_wr) begin
            case (reg_ix)
                gpk_pkg::REG_PEAK_COUNT: begin
                    r_peak_count <= pwdata[1:0];
                end
                gpk_pkg::REG_SHARED_WIDTH: begin
                    r_shared_width <= pwdata[0];
                end
                gpk_pkg::REG_BIN_WIDTH: begin
                    r_bin_width <= pwdata[30:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_ix)
            gpk_pkg::REG_PEAK_COUNT:   prdata = {30'd0, r_peak_count};
            gpk_pkg::REG_SHARED_WIDTH: prdata = {31'd0, r_shared_width};
            gpk_pkg::REG_BIN_WIDTH:    prdata = {1'b0, r_bin_width};
            default:                   prdata = '0;
        endcase
    end

    // Peak scale. It is registered from bin_width, and lanes read it as they
    // take a transaction from the stage 0 registers, so a transaction right
    // after a write sees the new value.
    assign cprod = r_bin_width * gpk_pkg::INV_SQRT_2PI;

    always_ff @(posedge i_clk) begin
        r_c <= cprod[61:32];
    end

    // ---------------------------------------------------------------
    // Flow control. The pipe advances unless the output register holds a
    // result the consumer is stalling.
    // ---------------------------------------------------------------
    assign en      = !(r_vld[gpk_pkg::IX_OUT] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[gpk_pkg::IX_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= gpk_pkg::IX_OUT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= gpk_pkg::IX_OUT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: capture. Width sharing and the peak enable are resolved
    // here so the lanes see one width and one used flag each.
    // ---------------------------------------------------------------
    always_comb begin
        in_area[0] = i_area_0;
        in_area[1] = i_area_1;
        in_area[2] = i_area_2;
        in_ctr[0]  = i_center_0;
        in_ctr[1]  = i_center_1;
        in_ctr[2]  = i_center_2;
        in_wid[0]  = i_width_0;
        in_wid[1]  = i_width_1;
        in_wid[2]  = i_width_2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x     <= i_sample_position;
            r_lvl   <= i_bg_level;
            r_slope <= i_bg_slope;
            for (int k = 0; k < gpk_pkg::MAX_PEAKS; k++) begin
                r_area[k] <= in_area[k];
                r_ctr[k]  <= in_ctr[k];
                r_wid[k]  <= r_shared_width ? i_width_0 : in_wid[k];
                r_used[k] <= 2'(k) < r_peak_count;
            end
        end
    end

    // ---------------------------------------------------------------
    // Background: exact slope*x, floored to Q.16 by the arithmetic shift.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bgp   <= r_slope * r_x;
            r_lvl_d <= r_lvl;
            r_bg[2] <= gpk_pkg::BG_W'(r_lvl_d) + gpk_pkg::BG_W'(r_bgp >>> 16);
            for (int s = 3; s < gpk_pkg::IX_SA; s++) begin
                r_bg[s] <= r_bg[s-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Peak lanes: one per peak, all in lockstep with the valid chain.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < gpk_pkg::MAX_PEAKS; k++) begin : g_peak
        always_comb begin
            pk_in[k].x      = r_x;
            pk_in[k].area   = r_area[k];
            pk_in[k].center = r_ctr[k];
            pk_in[k].width  = r_wid[k];
            pk_in[k].used   = r_used[k];
            pk_in[k].c      = r_c;
        end

        gpk_peak u_peak (
            .i_clk (i_clk),
            .i_en  (en),
            .i_pk  (pk_in[k]),
            .o_pk  (pk_out[k])
        );
    end

    // ---------------------------------------------------------------
    // Sum: background plus first peak, and the other peaks, then total.
    // A term overflow or a bad width from any lane is ORed in.
    // ---------------------------------------------------------------
    always_comb begin
        sa      = gpk_pkg::SA_W'(r_bg[gpk_pkg::IX_SA-1]) + gpk_pkg::SA_W'(pk_out[0].term);
        sb      = '0;
        ov_any  = 1'b0;
        bad_any = 1'b0;
        for (int k = 0; k < gpk_pkg::MAX_PEAKS; k++) begin
            if (k > 0) begin
                sb = sb + gpk_pkg::SA_W'(pk_out[k].term);
            end
            ov_any  = ov_any | pk_out[k].over;
            bad_any = bad_any | pk_out[k].bad;
        end
    end

    // clip when the sign bits above the 48-bit range disagree
    assign clip = (r_sum[gpk_pkg::SUM_W-1:gpk_pkg::OUT_W-1] != '0) &&
                  (r_sum[gpk_pkg::SUM_W-1:gpk_pkg::OUT_W-1] != '1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa      <= sa;
            r_sb      <= sb;
            r_ov_sa   <= ov_any;
            r_bad_sa  <= bad_any;
            r_sum     <= gpk_pkg::SUM_W'(r_sa) + gpk_pkg::SUM_W'(r_sb);
            r_ov_sum  <= r_ov_sa;
            r_bad_sum <= r_bad_sa;
            if (clip) begin
                r_out_value <= r_sum[gpk_pkg::SUM_W-1]
                               ? {1'b1, {(gpk_pkg::OUT_W-1){1'b0}}}
                               : {1'b0, {(gpk_pkg::OUT_W-1){1'b1}}};
            end else begin
                r_out_value <= r_sum[gpk_pkg::OUT_W-1:0];
            end
            r_out_sat <= r_ov_sum || clip;
            r_out_bad <= r_bad_sum;
        end
    end

    assign o_model_value = r_out_value;
    assign o_saturated   = r_out_sat;
    assign o_bad_width   = r_out_bad;

endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 30;
    localparam int CYCLE_CAP  = 1000000;
    localparam int TAB_DEPTH  = 256;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -64'sd140737488355328;
    localparam longint TERM_CLIP = 64'sd281474976710656;

    // one input transaction
    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] level;
        logic signed [31:0] slope;
        logic signed [31:0] area [3];
        logic signed [31:0] center [3];
        logic [30:0]        width [3];
    } spectrum_point_t;

    // one result transaction
    typedef struct {
        logic signed [47:0] value;
        logic               sat;
        logic               bad;
    } model_out_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_sample_position = '0;
    logic signed [31:0] i_bg_level = '0;
    logic signed [31:0] i_bg_slope = '0;
    logic signed [31:0] i_area_0 = '0, i_area_1 = '0, i_area_2 = '0;
    logic signed [31:0] i_center_0 = '0, i_center_1 = '0, i_center_2 = '0;
    logic [30:0]        i_width_0 = '0, i_width_1 = '0, i_width_2 = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [47:0] o_model_value;
    logic o_saturated;
    logic o_bad_width;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [gpk_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    gaussian_peaks_on_linear_background dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // testbench copy of the configuration registers
    logic [1:0]  cfg_peaks  = 2'd1;
    logic        cfg_shared = 1'b0;
    logic [30:0] cfg_bin    = 31'd65536;

    longint unsigned gauss_tab [0:TAB_DEPTH];
    model_out_t      pending_values [$];
    int              fail_count = 0;
    longint          cycle_count = 0;

    // exp(-16k/D) table, Q30 Taylor seed, rounded products
    task automatic build_gauss_tab();
        longint unsigned term, sum, v, n;
        term = 64'd1 << 30;
        sum  = term;
        v    = term;
        for (n = 1; n <= 24; n++) begin
            term = (term * 16) / (TAB_DEPTH * n);
            if (n[0]) begin
                sum -= term;
            end else begin
                sum += term;
            end
        end
        for (int k = 0; k <= TAB_DEPTH; k++) begin
            gauss_tab[k] = (v + 64'd8192) >> 14;
            v = (v * sum + (64'd1 << 29)) >> 30;
        end
    endtask

    // exp(-u^2/2) with u in Q16.16, table plus linear interpolation
    function automatic longint unsigned gauss_lookup(longint unsigned u);
        longint unsigned z, p, idx, f, lo, hi;
        if (u >= (64'd1 << 20)) return 0;
        z   = (u * u) >> 17;
        p   = (z * TAB_DEPTH) >> 4;
        idx = p >> 16;
        f   = p & 64'hFFFF;
        if (idx >= TAB_DEPTH) return 0;
        lo = gauss_tab[idx];
        hi = gauss_tab[idx + 1];
        if (lo >= hi) return lo - (((lo - hi) * f) >> 16);
        return lo + (((hi - lo) * f) >> 16);
    endfunction

    // background plus peak sum for one point under the current registers
    function automatic model_out_t model_eval(spectrum_point_t s);
        model_out_t r;
        longint x, acc, d, ar, mag, prod;
        longint unsigned c, w, ad, u, e, amp, g, aa;
        int npk;
        x   = s.pos;
        prod = longint'(s.slope) * x;
        acc = longint'(s.level) + (prod >>> 16);
        c   = (longint'(cfg_bin) * 64'd1713444047) >> 32;
        npk = cfg_peaks > 3 ? 3 : cfg_peaks;
        r.sat = 1'b0;
        r.bad = 1'b0;
        for (int p = 0; p < npk; p++) begin
            ar = s.area[p];
            w  = cfg_shared ? s.width[0] : s.width[p];
            if (w == 0) begin
                r.bad = 1'b1;
                continue;
            end
            d  = x - longint'(s.center[p]);
            ad = d < 0 ? -d : d;
            u  = (ad << 16) / w;
            e  = gauss_lookup(u);
            if (e == 0 || ar == 0) continue;
            amp = (c << 16) / w;
            g   = (amp * e) >> 16;
            aa  = ar < 0 ? -ar : ar;
            if (g != 0 && aa > 64'h7FFFFFFFFFFFFFFF / g) begin
                mag = TERM_CLIP;
                r.sat = 1'b1;
            end else begin
                mag = (g * aa) >> 16;
            end
            acc += ar < 0 ? -mag : mag;
        end
        if (acc > SUM_HI) begin
            acc = SUM_HI;
            r.sat = 1'b1;
        end else if (acc < SUM_LO) begin
            acc = SUM_LO;
            r.sat = 1'b1;
        end
        r.value = acc[47:0];
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    logic stall_free = 1'b0;   // phases with no receiver stalls

    // receiver stall generator
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (stall_free || !i_rst_n) begin
                i_stall <= 1'b0;
            end else begin
                n = gap_len();
                i_stall <= (n != 0);
                repeat (n > 0 ? n - 1 : 0) @(posedge i_clk);
            end
        end
    end

    // result checker: sample at the edge, compare with oldest expectation
    always @(posedge i_clk) begin
        model_out_t want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_values.size() == 0) begin
                $display("%0t unexpected result: got value %0d sat %0b bad %0b",
                         $realtime, o_model_value, o_saturated, o_bad_width);
                fail_count++;
            end else begin
                want = pending_values.pop_front();
                if (o_model_value !== want.value) begin
                    $display("%0t model_value expected %0d actual %0d",
                             $realtime, want.value, o_model_value);
                    fail_count++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t saturated expected %0b actual %0b",
                             $realtime, want.sat, o_saturated);
                    fail_count++;
                end
                if (o_bad_width !== want.bad) begin
                    $display("%0t bad_width expected %0b actual %0b",
                             $realtime, want.bad, o_bad_width);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // send one transaction; valid stays up across back-to-back items
    task automatic send_point(spectrum_point_t s);
        int n;
        n = gap_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_sample_position <= s.pos;
        i_bg_level        <= s.level;
        i_bg_slope        <= s.slope;
        i_area_0 <= s.area[0]; i_center_0 <= s.center[0]; i_width_0 <= s.width[0];
        i_area_1 <= s.area[1]; i_center_1 <= s.center[1]; i_width_1 <= s.width[1];
        i_area_2 <= s.area[2]; i_center_2 <= s.center[2]; i_width_2 <= s.width[2];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_values = {pending_values, model_eval(s)};
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // APB write: setup then access, pready is tied high
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= gpk_pkg::APB_AW'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gpk_pkg::REG_PEAK_COUNT:   cfg_peaks  = val[1:0];
            gpk_pkg::REG_SHARED_WIDTH: cfg_shared = val[0];
            default:                   cfg_bin    = val[30:0];
        endcase
    endtask

    task automatic set_config(logic [1:0] pk, logic sh, logic [30:0] bw);
        reg_write(gpk_pkg::REG_PEAK_COUNT, 32'(pk));
        reg_write(gpk_pkg::REG_SHARED_WIDTH, 32'(sh));
        reg_write(gpk_pkg::REG_BIN_WIDTH, 32'(bw));
    endtask

    function automatic logic [31:0] rnd_wide();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom();
        endcase
    endfunction

    // realistic peak: center near position, moderate width, mostly moderate area
    function automatic spectrum_point_t rnd_point(bit realistic);
        spectrum_point_t s;
        s.pos   = rnd_wide();
        s.level = realistic ? 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23))
                            : rnd_wide();
        s.slope = realistic ? 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17))
                            : rnd_wide();
        for (int p = 0; p < 3; p++) begin
            if (realistic) begin
                s.width[p]  = $urandom_range(0, 30) == 0 ? 31'd0
                              : 31'($urandom_range(1 << 12, 1 << 22));
                s.center[p] = s.pos + 32'($signed($urandom_range(0, 8 * s.width[p]))
                              - $signed(4 * s.width[p]));
                s.area[p]   = $urandom_range(0, 3) == 0 ? rnd_wide()
                              : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            end else begin
                s.width[p]  = $urandom_range(0, 5) == 0 ? 31'd0 : 31'($urandom());
                s.center[p] = rnd_wide();
                s.area[p]   = rnd_wide();
            end
        end
        return s;
    endfunction

    // extremes, zero widths, unused widths, far tail, overflow
    task automatic test_directed();
        spectrum_point_t s;
        s = rnd_point(1'b1);
        s.pos = 0; s.level = 0; s.slope = 0;
        s.center = '{0, 0, 0}; s.width = '{31'd65536, 31'd65536, 31'd65536};
        s.area = '{32'sd65536, 32'sd65536, 32'sd65536};
        send_point(s);                               // peak top
        s.width[1] = 0; send_point(s);               // unused zero width
        s.pos = 32'h8000_0000; s.slope = 32'h8000_0000; s.level = 32'h8000_0000;
        send_point(s);                               // most negative position, slope and level
        s.pos = 32'h8000_0000; s.slope = 32'h7FFF_FFFF; s.level = 32'h7FFF_FFFF;
        send_point(s);
        s.pos = 32'h7FFF_FFFF; s.slope = 32'h7FFF_FFFF; send_point(s);
        s.pos = 32'h0010_0000; s.level = 0; s.slope = 0; send_point(s);   // far tail
        s.pos = 0; s.width[0] = 31'd0; send_point(s);                     // used zero width
        drain();
        set_config(2'd3, 1'b0, 31'h7FFF_FFFF);
        s = rnd_point(1'b1);
        s.pos = 0; s.center = '{0, 0, 0};
        s.width = '{31'd1, 31'd1, 31'h7FFF_FFFF};
        s.area = '{32'h7FFF_FFFF, 32'h8000_0000, 32'sd1};
        send_point(s);                               // term overflow both signs
        s.width[1] = 0; send_point(s);               // zero width peak 1
        s.area = '{32'sd0, 32'sd0, 32'sd0}; send_point(s);
        s.width = '{31'd40000, 31'd0, 31'd0}; s.area = '{32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                          32'h7FFF_FFFF};
        send_point(s);                               // big term from peak 0, peaks 1 and 2 zero width
        drain();
        set_config(2'd3, 1'b1, 31'd1);               // shared width, tiny bin
        send_point(s);
        s.width[0] = 0; send_point(s);               // shared zero width: all bad
        drain();
        set_config(2'd0, 1'b0, 31'd0);               // no peaks, zero bin width
        send_point(s);
        drain();
    endtask

    // random stream under a series of register settings
    task automatic test_random();
        spectrum_point_t s;
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: set_config(2'd3, 1'b0, 31'd65536);
                1: set_config(2'd2, 1'b1, 31'($urandom()));
                2: set_config(2'd1, 1'b0, 31'h7FFF_FFFF);
                3: set_config(2'd3, 1'b1, 31'd1);
                4: set_config(2'd0, 1'b1, 31'($urandom_range(1, 1 << 20)));
                default: set_config(2'($urandom_range(0, 3)), 1'($urandom()),
                                    31'($urandom()));
            endcase
            stall_free = (phase == 2);
            for (int n = 0; n < 210; n++) begin
                s = rnd_point($urandom_range(0, 3) != 0);
                send_point(s);
                if (n == 100) drain();             // sender holds until empty
            end
        end
        stall_free = 1'b0;
        drain();
    endtask

    initial begin
        build_gauss_tab();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        if (fail_count == 0 && pending_values.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/gpk_pkg.sv
hw/rtl/gpk_peak.sv
hw/rtl/gaussian_peaks_on_linear_background.sv
verif/tb_top.sv
